/* hdl/ffea_pkg.sv */
`timescale 1ns / 1ps

package ffea_pkg;

   localparam int OFFSET_PORT_BITS = 31;
   localparam int SIZE_PORT_BITS = 32;
   localparam int CMD_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH = 2;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE = 1'b1;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_NOFIT = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef struct packed {
      status_type status;
      logic [OFFSET_PORT_BITS-1:0] alloc_offset;
   } rsp_type;

endpackage

/* hdl/ffea_fifo.sv */
`timescale 1ns / 1ps

module ffea_fifo import ffea_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input logic clock,
   input logic reset,
   input logic push,
   input logic [WIDTH-1:0] wdata,
   output logic full,
   input logic pop,
   output logic [WIDTH-1:0] rdata,
   output logic empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic do_push, do_pop;

   assign full = (fill_ff == FW'(DEPTH));
   assign empty = (fill_ff == '0);
   assign rdata = slot_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

/* hdl/ffea_front.sv */
`timescale 1ns / 1ps

module ffea_front import ffea_pkg::*; #(
   parameter int REGION_BITS = 31
) (
   input logic clock,
   input logic reset,
   input logic push,
   output logic full,
   input logic req_cmd,
   input logic [SIZE_PORT_BITS-1:0] req_size,
   input logic [OFFSET_PORT_BITS-1:0] req_offset,
   output logic cmd_empty,
   input logic cmd_pop,
   output logic cmd_op,
   output logic cmd_zero_free,
   output logic [SIZE_PORT_BITS-1:0] cmd_size,
   output logic [REGION_BITS:0] cmd_len,
   output logic [REGION_BITS-1:0] cmd_off
);

   localparam int LW = REGION_BITS + 1;
   localparam int SW = (LW > SIZE_PORT_BITS) ? LW : SIZE_PORT_BITS;
   localparam int QW = 2 + SIZE_PORT_BITS + LW + REGION_BITS;

   logic [SW-1:0] size_wide;
   logic [LW-1:0] sat_len;
   logic zero_free;
   logic [QW-1:0] q_wdata, q_rdata;

   // Release lengths saturate at the largest length a table entry can hold.
   assign size_wide = SW'(req_size);
   assign sat_len = (size_wide > SW'({LW{1'b1}})) ? {LW{1'b1}} : size_wide[LW-1:0];
   assign zero_free = (req_cmd == CMD_FREE) && (req_size == '0);
   assign q_wdata = {zero_free, req_cmd, req_size, sat_len, REGION_BITS'(req_offset)};

   ffea_fifo #(
      .WIDTH(QW),
      .DEPTH(CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .wdata(q_wdata),
      .full(full),
      .pop(cmd_pop),
      .rdata(q_rdata),
      .empty(cmd_empty)
   );

   assign {cmd_zero_free, cmd_op, cmd_size, cmd_len, cmd_off} = q_rdata;

endmodule

/* hdl/ffea_engine.sv */
`timescale 1ns / 1ps

module ffea_engine import ffea_pkg::*; #(
   parameter int MAX_EXTENTS = 16,
   parameter int REGION_BITS = 31
) (
   input logic clock,
   input logic reset,
   input logic cmd_empty,
   output logic cmd_pop,
   input logic cmd_op,
   input logic cmd_zero_free,
   input logic [SIZE_PORT_BITS-1:0] cmd_size,
   input logic [REGION_BITS:0] cmd_len,
   input logic [REGION_BITS-1:0] cmd_off,
   output logic rsp_push,
   output rsp_type rsp_data,
   input logic rsp_full
);

   localparam int OW = REGION_BITS;
   localparam int LW = REGION_BITS + 1;
   localparam int IW = $clog2(MAX_EXTENTS);
   localparam int CW = $clog2(MAX_EXTENTS + 1);
   localparam int CMPW = LW + SIZE_PORT_BITS;

   typedef struct packed {
      logic [OW-1:0] start;
      logic [LW-1:0] len;
   } entry_type;

   typedef enum logic [6:0] {
      S_INIT = 7'b0000001,
      S_IDLE = 7'b0000010,
      S_SCAN = 7'b0000100,
      S_DOWN = 7'b0001000,
      S_UP = 7'b0010000,
      S_INS = 7'b0100000,
      S_RESP = 7'b1000000
   } state_type;

   entry_type mem [MAX_EXTENTS];
   entry_type rd_ff, prev_ff, prev_in, wr_data;
   logic [IW-1:0] rd_addr, wr_addr;
   logic wr_en;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, k_ff, k_in, pos_ff, pos_in;
   logic [CW-1:0] k_inc, k_dec;
   logic op_ff, op_in;
   logic [SIZE_PORT_BITS-1:0] size_ff, size_in;
   logic [LW-1:0] len_ff, len_in;
   logic [OW-1:0] off_ff, off_in;
   status_type status_ff, status_in;
   logic [OW-1:0] result_ff, result_in;

   logic at_end, fits, exact, join_next, join_prev;
   logic [LW:0] prev_end, free_end, sum_prev, sum_next;
   logic [LW+1:0] sum_both;
   logic [LW-1:0] len_prev, len_next, len_both;

   assign k_inc = k_ff + 1'b1;
   assign k_dec = k_ff - 1'b1;
   assign at_end = (k_ff == count_ff);
   assign fits = (CMPW'(rd_ff.len) >= CMPW'(size_ff));
   assign exact = (CMPW'(rd_ff.len) == CMPW'(size_ff));

   // Merge tests and saturating merged lengths; the sums are one bit wider than a length, the three-way sum two.
   assign prev_end = (LW + 1)'(prev_ff.start) + (LW + 1)'(prev_ff.len);
   assign free_end = (LW + 1)'(off_ff) + (LW + 1)'(len_ff);
   assign join_prev = (k_ff != '0) && (prev_end == (LW + 1)'(off_ff));
   assign join_next = !at_end && (free_end == (LW + 1)'(rd_ff.start));
   assign sum_prev = (LW + 1)'(prev_ff.len) + (LW + 1)'(len_ff);
   assign sum_next = (LW + 1)'(len_ff) + (LW + 1)'(rd_ff.len);
   assign sum_both = (LW + 2)'(prev_ff.len) + (LW + 2)'(len_ff) + (LW + 2)'(rd_ff.len);
   assign len_prev = sum_prev[LW] ? {LW{1'b1}} : sum_prev[LW-1:0];
   assign len_next = sum_next[LW] ? {LW{1'b1}} : sum_next[LW-1:0];
   assign len_both = (sum_both[LW+1:LW] != 2'b00) ? {LW{1'b1}} : sum_both[LW-1:0];

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      k_in = k_ff;
      pos_in = pos_ff;
      prev_in = prev_ff;
      op_in = op_ff;
      size_in = size_ff;
      len_in = len_ff;
      off_in = off_ff;
      status_in = status_ff;
      result_in = result_ff;
      rd_addr = k_inc[IW-1:0];
      wr_en = 1'b0;
      wr_addr = k_ff[IW-1:0];
      wr_data = rd_ff;
      cmd_pop = 1'b0;
      rsp_push = 1'b0;
      case (state_ff)
         S_INIT: begin
            wr_en = 1'b1;
            wr_addr = '0;
            wr_data.start = '0;
            wr_data.len = {1'b1, {OW{1'b0}}};
            state_in = S_IDLE;
         end
         S_IDLE: begin
            rd_addr = '0;
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               op_in = cmd_op;
               size_in = cmd_size;
               len_in = cmd_len;
               off_in = cmd_off;
               k_in = '0;
               status_in = ST_DONE;
               result_in = '0;
               state_in = cmd_zero_free ? S_RESP : S_SCAN;
            end
         end
         S_SCAN: begin
            // The read data holds entry k whenever k is below the count.
            if (op_ff == CMD_ALLOC) begin
               if (at_end) begin
                  status_in = ST_NOFIT;
                  state_in = S_RESP;
               end else if (fits) begin
                  result_in = rd_ff.start;
                  if (exact) begin
                     state_in = S_DOWN;
                  end else begin
                     wr_en = 1'b1;
                     wr_data.start = rd_ff.start + OW'(size_ff);
                     wr_data.len = rd_ff.len - LW'(size_ff);
                     state_in = S_RESP;
                  end
               end else begin
                  k_in = k_inc;
               end
            end else if (!at_end && (rd_ff.start < off_ff)) begin
               prev_in = rd_ff;
               k_in = k_inc;
            end else if (join_prev && join_next) begin
               wr_en = 1'b1;
               wr_addr = k_dec[IW-1:0];
               wr_data.start = prev_ff.start;
               wr_data.len = len_both;
               state_in = S_DOWN;
            end else if (join_prev) begin
               wr_en = 1'b1;
               wr_addr = k_dec[IW-1:0];
               wr_data.start = prev_ff.start;
               wr_data.len = len_prev;
               state_in = S_RESP;
            end else if (join_next) begin
               wr_en = 1'b1;
               wr_data.start = off_ff;
               wr_data.len = len_next;
               state_in = S_RESP;
            end else if (count_ff == CW'(MAX_EXTENTS)) begin
               status_in = ST_FULL;
               state_in = S_RESP;
            end else if (at_end) begin
               wr_en = 1'b1;
               wr_data.start = off_ff;
               wr_data.len = len_ff;
               count_in = count_ff + 1'b1;
               state_in = S_RESP;
            end else begin
               // Open a hole at k by moving the tail up one entry, last first.
               pos_in = k_ff;
               k_in = count_ff;
               rd_addr = k_dec[IW-1:0];
               rd_addr = IW'(count_ff - 1'b1);
               state_in = S_UP;
            end
         end
         S_DOWN: begin
            // Entry k takes entry k + 1, whose read was issued last cycle.
            if (k_inc == count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_RESP;
            end else begin
               wr_en = 1'b1;
               rd_addr = IW'(k_ff + CW'(2));
               k_in = k_inc;
            end
         end
         S_UP: begin
            wr_en = 1'b1;
            k_in = k_dec;
            rd_addr = IW'(k_ff - CW'(2));
            if (k_dec == pos_ff) begin
               state_in = S_INS;
            end
         end
         S_INS: begin
            wr_en = 1'b1;
            wr_addr = pos_ff[IW-1:0];
            wr_data.start = off_ff;
            wr_data.len = len_ff;
            count_in = count_ff + 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_data.status = status_ff;
   assign rsp_data.alloc_offset = OFFSET_PORT_BITS'(result_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         count_ff <= CW'(1);
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      pos_ff <= pos_in;
      prev_ff <= prev_in;
      op_ff <= op_in;
      size_ff <= size_in;
      len_ff <= len_in;
      off_ff <= off_in;
      status_ff <= status_in;
      result_ff <= result_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

endmodule

/* hdl/first_fit_extent_allocator.sv */
`timescale 1ns / 1ps

// Channel    Direction  Ports                                   Transfer when
// request    in         req_cmd, req_size, req_offset           push && !full
// response   out        rsp_status, rsp_alloc_offset            pop && !empty
//
// A request is queued on entry and worked off by one engine over the extent table memory.
// An allocation walks the table from entry 0 to the first extent that fits and, on an exact
// fit, moves the later entries down one; a release walks to its place, then merges, or moves
// the later entries up one to insert or down one to remove an entry after a double merge.
// Reset is synchronous; the first cycle after reset writes the whole-region extent.
// Either side may stall: two requests and two responses can wait in their queues.

module first_fit_extent_allocator import ffea_pkg::*; #(
   parameter int MAX_EXTENTS = 16,
   parameter int REGION_BITS = 31
) (
   input logic clock,
   input logic reset,
   input logic push,
   output logic full,
   input logic req_cmd,
   input logic [SIZE_PORT_BITS-1:0] req_size,
   input logic [OFFSET_PORT_BITS-1:0] req_offset,
   output logic empty,
   input logic pop,
   output logic [1:0] rsp_status,
   output logic [OFFSET_PORT_BITS-1:0] rsp_alloc_offset
);

   logic cmd_empty, cmd_pop, cmd_op, cmd_zero_free;
   logic [SIZE_PORT_BITS-1:0] cmd_size;
   logic [REGION_BITS:0] cmd_len;
   logic [REGION_BITS-1:0] cmd_off;
   logic rsp_push, rsp_full;
   rsp_type rsp_data, rsp_head;
   logic [$bits(rsp_type)-1:0] rsp_rdata;

   ffea_front #(
      .REGION_BITS(REGION_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_cmd(req_cmd),
      .req_size(req_size),
      .req_offset(req_offset),
      .cmd_empty(cmd_empty),
      .cmd_pop(cmd_pop),
      .cmd_op(cmd_op),
      .cmd_zero_free(cmd_zero_free),
      .cmd_size(cmd_size),
      .cmd_len(cmd_len),
      .cmd_off(cmd_off)
   );

   ffea_engine #(
      .MAX_EXTENTS(MAX_EXTENTS),
      .REGION_BITS(REGION_BITS)
   ) u_engine (
      .clock(clock),
      .reset(reset),
      .cmd_empty(cmd_empty),
      .cmd_pop(cmd_pop),
      .cmd_op(cmd_op),
      .cmd_zero_free(cmd_zero_free),
      .cmd_size(cmd_size),
      .cmd_len(cmd_len),
      .cmd_off(cmd_off),
      .rsp_push(rsp_push),
      .rsp_data(rsp_data),
      .rsp_full(rsp_full)
   );

   ffea_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push(rsp_push),
      .wdata(rsp_data),
      .full(rsp_full),
      .pop(pop),
      .rdata(rsp_rdata),
      .empty(empty)
   );

   assign rsp_head = rsp_type'(rsp_rdata);
   assign rsp_status = rsp_head.status;
   assign rsp_alloc_offset = rsp_head.alloc_offset;

endmodule

/* hdl/ffea_checker.sv */
`timescale 1ns / 1ps

module ffea_checker import ffea_pkg::*; (
   input logic clock,
   input logic reset,
   input logic full,
   input logic empty,
   input logic pop,
   input logic [1:0] rsp_status,
   input logic [OFFSET_PORT_BITS-1:0] rsp_alloc_offset
);

   // Both queues come out of reset drained.
   a_empty_after_reset: assert property (@(posedge clock) reset |=> empty)
      else $error("response queue not empty after reset");

   a_ready_after_reset: assert property (@(posedge clock) reset |=> !full)
      else $error("request queue full after reset");

   // Only a successful allocation carries an offset.
   a_offset_on_fail: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status != ST_DONE) |-> rsp_alloc_offset == '0)
      else $error("nonzero offset on a failed response");

   a_held_response: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_status) && $stable(rsp_alloc_offset)))
      else $error("waiting response changed before its transfer");

endmodule

bind first_fit_extent_allocator ffea_checker u_checker (.*);

/* verif/tb_first_fit_extent_allocator.sv */
`timescale 1ns / 1ps

module tb_first_fit_extent_allocator;
   import ffea_pkg::*;

   localparam int NUM_EXTENTS = 16;
   localparam int REG_BITS = 31;
   localparam longint unsigned OFF_MASK = (64'd1 << REG_BITS) - 1;
   localparam longint unsigned LEN_MAX = (64'd1 << (REG_BITS + 1)) - 1;
   localparam longint unsigned REGION_SIZE = 64'd1 << REG_BITS;
   localparam int RANDOM_ITEMS = 1700;
   localparam longint CYCLE_LIMIT = 1500000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic req_cmd = CMD_ALLOC;
   logic [SIZE_PORT_BITS-1:0] req_size = '0;
   logic [OFFSET_PORT_BITS-1:0] req_offset = '0;
   logic full, empty;
   logic [1:0] rsp_status;
   logic [OFFSET_PORT_BITS-1:0] rsp_alloc_offset;

   first_fit_extent_allocator #(.MAX_EXTENTS(NUM_EXTENTS), .REGION_BITS(REG_BITS)) uut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_cmd(req_cmd), .req_size(req_size), .req_offset(req_offset),
      .empty(empty), .pop(pop), .rsp_status(rsp_status),
      .rsp_alloc_offset(rsp_alloc_offset)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Free list mirror.
   longint unsigned free_start[NUM_EXTENTS];
   longint unsigned free_len[NUM_EXTENTS];
   int free_count;

   rsp_type pending_rsp[$];
   int error_count = 0;
   longint cycle_count = 0;
   bit stimulus_done = 1'b0;

   typedef struct {
      logic cmd;
      logic [31:0] size;
      logic [30:0] offset;
      bit has_expected;
      status_type status;
      logic [30:0] alloc_offset;
   } stim_row;

   stim_row directed[$];

   function automatic longint unsigned clip_len(longint unsigned v);
      return v > LEN_MAX ? LEN_MAX : v;
   endfunction

   function automatic void remove_extent(int pos);
      for (int i = pos; i + 1 < free_count; i++) begin
         free_start[i] = free_start[i + 1];
         free_len[i] = free_len[i + 1];
      end
      free_count--;
   endfunction

   function automatic rsp_type predict_allocator(logic cmd, logic [31:0] size,
                                                 logic [30:0] offset);
      rsp_type r;
      int pos;
      bit join_next, join_prev;
      longint unsigned sz, off;
      r.status = ST_DONE;
      r.alloc_offset = '0;
      pos = 0;
      sz = size;
      off = offset & OFF_MASK;
      if (cmd == CMD_ALLOC) begin
         r.status = ST_NOFIT;
         for (int i = 0; i < free_count; i++) begin
            if (free_len[i] >= sz) begin
               r.status = ST_DONE;
               r.alloc_offset = free_start[i];
               if (free_len[i] == sz) remove_extent(i);
               else begin
                  free_start[i] = (free_start[i] + sz) & OFF_MASK;
                  free_len[i] -= sz;
               end
               break;
            end
         end
      end else if (sz != 0) begin
         sz = clip_len(sz);
         while (pos < free_count && free_start[pos] < off) pos++;
         join_next = pos < free_count && off + sz == free_start[pos];
         join_prev = pos > 0 && free_start[pos - 1] + free_len[pos - 1] == off;
         if (join_next && join_prev) begin
            free_len[pos - 1] = clip_len(free_len[pos - 1] + sz + free_len[pos]);
            remove_extent(pos);
         end else if (join_prev) begin
            free_len[pos - 1] = clip_len(free_len[pos - 1] + sz);
         end else if (join_next) begin
            free_start[pos] = off;
            free_len[pos] = clip_len(sz + free_len[pos]);
         end else if (free_count >= NUM_EXTENTS) begin
            r.status = ST_FULL;
         end else begin
            for (int i = free_count; i > pos; i--) begin
               free_start[i] = free_start[i - 1];
               free_len[i] = free_len[i - 1];
            end
            free_start[pos] = off;
            free_len[pos] = sz;
            free_count++;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   function automatic void add_row(logic cmd, logic [31:0] size, logic [30:0] offset,
                                   bit has_exp = 0, status_type st = ST_DONE,
                                   logic [30:0] ao = '0);
      stim_row row;
      row.cmd = cmd;
      row.size = size;
      row.offset = offset;
      row.has_expected = has_exp;
      row.status = st;
      row.alloc_offset = ao;
      directed.push_back(row);
   endfunction

   // One transfer on the request side, with the expectation queued as it is accepted.
   task automatic send_request(logic cmd, logic [31:0] size, logic [30:0] offset,
                               bit has_exp, status_type st, logic [30:0] ao);
      rsp_type r;
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      push <= 1'b1;
      req_cmd <= cmd;
      req_size <= size;
      req_offset <= offset;
      do @(posedge clock); while (full);
      r = predict_allocator(cmd, size, offset);
      if (has_exp && (r.status != st || r.alloc_offset != ao))
         report_mismatch($sformatf("typed expectation disagrees with predictor, cmd %0d", cmd));
      pending_rsp.push_back(r);
      @(negedge clock);
   endtask

   function automatic logic [31:0] random_size();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'h8000_0000;
         2: return 0;
         3, 4: return $urandom_range(1, 64);
         default: return $urandom_range(1, 4096) << $urandom_range(0, 12);
      endcase
   endfunction

   // Releases mostly hand back earlier grants whole so merges and refills happen.
   logic [30:0] granted_off[$];
   logic [31:0] granted_size[$];

   initial begin
      rsp_type r;
      int k;
      logic [31:0] sz;
      free_count = 1;
      free_start[0] = 0;
      free_len[0] = REGION_SIZE;

      add_row(CMD_ALLOC, 0, 31'h7FFF_FFFF, 1, ST_DONE, 0);
      add_row(CMD_ALLOC, 32'h100, 0, 1, ST_DONE, 0);
      add_row(CMD_ALLOC, 32'hFFFF_FFFF, 0, 1, ST_NOFIT, 0);
      add_row(CMD_FREE, 0, 31'h1234, 1, ST_DONE, 0);
      add_row(CMD_FREE, 32'h80, 0);
      add_row(CMD_FREE, 32'h80, 31'h80);
      add_row(CMD_ALLOC, 32'h8000_0000, 0);
      add_row(CMD_ALLOC, 0, 0, 1, ST_NOFIT, 0);
      add_row(CMD_FREE, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
      add_row(CMD_ALLOC, 32'h10, 0);
      add_row(CMD_FREE, 32'h10, 31'h0);
      add_row(CMD_FREE, 32'h10, 31'h0);
      for (int i = 0; i < 12; i++) add_row(CMD_FREE, 32'h1, 31'(32'h100 + 4 * i));

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_request(directed[i].cmd, directed[i].size, directed[i].offset,
                      directed[i].has_expected, directed[i].status, directed[i].alloc_offset);
      push <= 1'b0;

      // Let the directed traffic drain before the random part starts.
      wait (pending_rsp.size() == 0);
      repeat (2 * NUM_EXTENTS + 8) @(negedge clock);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         k = $urandom_range(0, 9);
         if (k < 5) begin
            sz = random_size();
            r = '0;
            send_request(CMD_ALLOC, sz, 31'($urandom()), 0, ST_DONE, 0);
            if (pending_rsp.size() > 0 && pending_rsp[$].status == ST_DONE && sz != 0) begin
               granted_off.push_back(pending_rsp[$].alloc_offset);
               granted_size.push_back(sz);
            end
         end else if (k < 9 && granted_off.size() > 0) begin
            k = $urandom_range(0, granted_off.size() - 1);
            send_request(CMD_FREE, granted_size[k], granted_off[k], 0, ST_DONE, 0);
            granted_off.delete(k);
            granted_size.delete(k);
         end else begin
            send_request(CMD_FREE, random_size(), 31'($urandom()), 0, ST_DONE, 0);
         end
      end
      push <= 1'b0;
      stimulus_done = 1'b1;
   end

   // Response side: random pop gaps, compare on accepted transfers.
   initial begin
      rsp_type exp_rsp;
      int gap;
      @(negedge clock);
      while (1) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         if (pending_rsp.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_status != exp_rsp.status)
               report_mismatch($sformatf("status %0d, expected %0d", rsp_status, exp_rsp.status));
            if (rsp_alloc_offset != exp_rsp.alloc_offset)
               report_mismatch($sformatf("alloc_offset %h, expected %h",
                                         rsp_alloc_offset, exp_rsp.alloc_offset));
         end
         @(negedge clock);
      end
   end

   initial begin
      wait (stimulus_done && pending_rsp.size() == 0);
      repeat (2 * NUM_EXTENTS + 20) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0)
         $display("first_fit_extent_allocator verification clean");
      else
         $display("first_fit_extent_allocator verification failed");
      $finish;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("first_fit_extent_allocator verification failed");
         $finish;
      end
   end

endmodule
